FILE: sv/ept_pkg.sv
// ----------------------------------------------------------------------------
// ept_pkg
// Shared types and constants for the equalized palette thresholds core.
// ----------------------------------------------------------------------------
package ept_pkg;

  localparam int SampleW = 24;
  localparam int IndexW  = 5;

  typedef enum logic [1:0] {
    MODE_FLAT = 2'd0,
    MODE_SNAP = 2'd1,
    MODE_HALF = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_LENGTH = 2'd1,
    REG_BORDER = 2'd2
  } reg_index_t;

endpackage

FILE: sv/ept_ram.sv
// ----------------------------------------------------------------------------
// ept_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ept_ram #(
  parameter int Width = 24,
  parameter int Depth = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/equalized_palette_thresholds_core.sv
// ----------------------------------------------------------------------------
// equalized_palette_thresholds_core
// Loads a sample grid, then computes equal-count palette thresholds by
// counting bisection over the stored samples.
// ----------------------------------------------------------------------------
// channel   dir  beat fields (lsb first)
// s_axis    in   tdata: sample[23:0]; tlast: last
// m_axis    out  tdata: thr_value[23:0]; tuser: thr_index[4:0]; tlast: thr_last
// cfg       in   cfg_index[1:0], cfg_data[23:0]
//
// Loading takes every beat that s_axis offers. After the last beat the core
// scans the store once for min/max, then each bisection step is one pass of
// the store plus an update, with all passes sharing the one sample RAM port,
// and each threshold first divides out its target count with a restoring
// divider. Mode 0 bisects each threshold once, mode 1 bisects them again
// around the border, and modes 1 and 2 add a border count pass.
// The sample RAM needs no clearing after reset. Results hold while m_axis
// stalls; s_axis is not ready from the last beat until the final result leaves.
// ----------------------------------------------------------------------------
module equalized_palette_thresholds_core #(
  parameter int MAX_SAMPLES  = 65536,
  parameter int MAX_BANDS    = 16,
  parameter int BISECT_STEPS = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // sample[23:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // thr_value[23:0]
  output logic [4:0]  m_axis_tuser,   // thr_index[4:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = AW + 1;
  localparam int TW = $clog2(MAX_BANDS + 1);
  localparam int SW = $clog2(BISECT_STEPS + 1);
  localparam int PW = CW + TW;

  typedef enum logic [3:0] {
    S_LOAD, S_MM, S_SETUP, S_PLAN, S_COUNT, S_STEP, S_DIV, S_SNAP,
    S_BCOUNT, S_EMIT
  } state_t;

  state_t state;
  logic [1:0]         mode;
  logic [4:0]         plen;
  logic signed [23:0] border;
  logic [CW-1:0]      count;
  logic [CW-1:0]      addr;
  logic [CW-1:0]      cnt;
  logic [1:0]         pipe;
  logic signed [23:0] low_value, high_value;
  logic signed [23:0] thr [MAX_BANDS+1];
  logic [TW-1:0]      len;
  logic [1:0]         m;
  logic [TW-1:0]      split;
  logic [CW-1:0]      below;
  logic [TW-1:0]      ti;
  logic [SW-1:0]      step;
  logic [1:0]         phase;
  logic signed [23:0] lo, hi, th;
  logic [CW-1:0]      target;
  logic [PW-1:0]      num;
  logic [TW-1:0]      den;
  logic [CW-1:0]      quo;
  logic [CW-1:0]      base;
  logic [CW-1:0]      rem;
  logic [5:0]         dbit;
  logic signed [25:0] best;
  logic [TW-1:0]      oi;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic signed [23:0] rdata;
  logic               take;

  assign take      = s_axis_tvalid && s_axis_tready;
  assign ram_we    = take && (count < CW'(MAX_SAMPLES));
  assign ram_addr  = (state == S_LOAD) ? count[AW-1:0] : addr[AW-1:0];
  assign s_axis_tready = (state == S_LOAD);
  assign cfg_ready = 1'b1;

  ept_ram #(.Width(24), .Depth(MAX_SAMPLES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(s_axis_tdata), .rdata(rdata)
  );

  function automatic logic signed [23:0] mid(input logic signed [23:0] a,
                                             input logic signed [23:0] b);
    logic signed [24:0] s;
    s = 25'(a) + 25'(b);
    return s[24:1];
  endfunction

  logic signed [25:0] gap;
  logic [PW:0]        trial;
  assign gap   = 26'(thr[ti]) - 26'(border);
  assign trial = (PW+1)'({rem, num[PW-1]});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      mode <= 2'd0; plen <= 5'd11; border <= '0;
      count <= '0; m_axis_tvalid <= 1'b0;
      low_value <= '0; high_value <= '0;
      split <= '0; below <= '0;
      for (int k = 0; k <= MAX_BANDS; k++) thr[k] <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          ept_pkg::REG_MODE:   mode <= cfg_data[1:0];
          ept_pkg::REG_LENGTH: plen <= cfg_data[4:0];
          ept_pkg::REG_BORDER: border <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_LOAD: if (take) begin
          if (count < CW'(MAX_SAMPLES)) count <= count + 1'b1;
          if (s_axis_tlast) begin
            state <= S_MM; addr <= '0; cnt <= '0; pipe <= '0;
            if (plen < 5'd2) len <= TW'(2);
            else if (32'(plen) > MAX_BANDS) len <= TW'(MAX_BANDS);
            else len <= TW'(plen);
            m <= (mode == 2'd3) ? ept_pkg::MODE_HALF : mode;
          end
        end
        S_MM: begin
          // pipe[0]: read issued last cycle, rdata valid; pipe[1]: pipe[0] delayed
          if (addr < count) addr <= addr + 1'b1;
          pipe <= {pipe[0], addr < count};
          if (pipe[0]) begin
            if (cnt == '0) begin low_value <= rdata; high_value <= rdata; end
            else begin
              if (rdata > high_value) high_value <= rdata;
              if (rdata < low_value) low_value <= rdata;
            end
            cnt <= cnt + 1'b1;
          end
          if (!pipe[0] && !pipe[1] && !(addr < count)) state <= S_SETUP;
        end
        S_SETUP: begin
          thr[0] <= low_value; thr[len] <= high_value;
          split <= len >> 1; below <= '0;
          ti <= TW'(1);
          phase <= (m == ept_pkg::MODE_HALF) ? 2'd1 : 2'd0;
          if (m == ept_pkg::MODE_HALF) begin
            state <= S_BCOUNT; addr <= '0; cnt <= '0; pipe <= '0;
          end else state <= S_PLAN;
        end
        S_PLAN: begin
          // phase 0 flat, 1 below border, 2 above border
          if (phase == 2'd0 && ti >= len) begin
            if (m == ept_pkg::MODE_SNAP) begin
              state <= S_SNAP; ti <= TW'(1);
              best <= 26'(high_value) - 26'(low_value);
            end else begin state <= S_EMIT; oi <= '0; end
          end else if (phase == 2'd1 && ti >= split) begin
            phase <= 2'd2; ti <= split + 1'b1;
          end else if (phase == 2'd2 && ti >= len) begin
            state <= S_EMIT; oi <= '0;
          end else begin
            if (phase == 2'd0) begin
              num <= PW'(count) * PW'(ti); den <= len; base <= '0;
            end else if (phase == 2'd1) begin
              num <= PW'(below) * PW'(ti); den <= split; base <= '0;
            end else begin
              num <= PW'(count - below) * PW'(ti - split);
              den <= len - split; base <= below;
            end
            rem <= '0; quo <= '0; dbit <= 6'(PW); state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (dbit != '0) begin
            num <= num << 1;
            if (trial >= (PW+1)'(den)) begin
              rem <= CW'(trial - (PW+1)'(den)); quo <= {quo[CW-2:0], 1'b1};
            end else begin
              rem <= CW'(trial); quo <= {quo[CW-2:0], 1'b0};
            end
            dbit <= dbit - 1'b1;
          end else begin
            target <= base + quo;
            lo <= (phase == 2'd2) ? border : low_value;
            hi <= (phase == 2'd1) ? border : high_value;
            th <= mid((phase == 2'd2) ? border : low_value,
                      (phase == 2'd1) ? border : high_value);
            step <= '0;
            state <= S_COUNT; addr <= '0; cnt <= '0; pipe <= '0;
          end
        end
        S_COUNT: begin
          if (addr < count) addr <= addr + 1'b1;
          pipe <= {pipe[0], addr < count};
          if (pipe[0] && rdata < th) cnt <= cnt + 1'b1;
          if (!pipe[0] && !pipe[1] && !(addr < count)) state <= S_STEP;
        end
        S_STEP: begin
          if (cnt > target) begin hi <= th; th <= mid(lo, th); end
          else begin lo <= th; th <= mid(th, hi); end
          if (32'(step) == BISECT_STEPS - 1) begin
            thr[ti] <= (cnt > target) ? mid(lo, th) : mid(th, hi);
            ti <= ti + 1'b1; state <= S_PLAN;
          end else begin
            step <= step + 1'b1;
            state <= S_COUNT; addr <= '0; cnt <= '0; pipe <= '0;
          end
        end
        S_SNAP: begin
          if (ti < len) begin
            if ((gap < 0 ? -gap : gap) < best) begin
              best <= (gap < 0 ? -gap : gap); split <= ti;
            end
            ti <= ti + 1'b1;
          end else begin
            state <= S_BCOUNT; addr <= '0; cnt <= '0; pipe <= '0;
          end
        end
        S_BCOUNT: begin
          if (addr < count) addr <= addr + 1'b1;
          pipe <= {pipe[0], addr < count};
          if (pipe[0] && rdata < border) cnt <= cnt + 1'b1;
          if (!pipe[0] && !pipe[1] && !(addr < count)) begin
            below <= cnt; thr[split] <= border;
            phase <= 2'd1; ti <= TW'(1); state <= S_PLAN;
          end
        end
        S_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            if (m_axis_tvalid && m_axis_tlast) begin
              m_axis_tvalid <= 1'b0; state <= S_LOAD; count <= '0;
            end else begin
              m_axis_tvalid <= 1'b1;
              m_axis_tuser  <= 5'(oi);
              m_axis_tdata  <= thr[oi];
              m_axis_tlast  <= (oi == len);
              oi <= oi + 1'b1;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) m_axis_tvalid |-> state == S_EMIT)
    else $error("result valid outside emit");
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_SAMPLES))
    else $error("sample count overflow");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the equalized palette thresholds core: streams
// sample grids with random gaps and back-pressure, predicts every threshold
// beat with a behavioral bisection model and compares it field by field.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [23:0] sample;
    logic        last;
  } sample_beat_t;

  typedef struct packed {
    logic [4:0]  index;
    logic [23:0] value;
    logic        last;
  } thr_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  ept_pkg::reg_index_t cfg_index = ept_pkg::REG_MODE;
  logic [23:0] cfg_data = '0;

  equalized_palette_thresholds_core uut (.*);

  always #6 clk = ~clk;

  sample_beat_t pending_samples[$];
  thr_beat_t    expected_thresholds[$];
  int           fail_count = 0;
  int           tx_wait = 0;
  int           rx_wait = 0;
  bit           in_taken = 1'b0;
  bit           tx_free;

  logic [1:0]  cur_mode = ept_pkg::MODE_FLAT;
  logic [4:0]  cur_length = 5'd11;
  logic [23:0] cur_border = '0;

  int grid[$];
  int thr_table[17];

  function automatic int sx24(logic [23:0] v);
    return int'($signed(v));
  endfunction

  function automatic int mid_floor(int a, int b);
    return (a + b) >>> 1;
  endfunction

  function automatic longint count_under(int t);
    longint n = 0;
    foreach (grid[k]) if (grid[k] < t) n++;
    return n;
  endfunction

  function automatic int bisect_threshold(int lo, int hi, longint target);
    int th = mid_floor(lo, hi);
    for (int k = 0; k < 15; k++) begin
      if (count_under(th) > target) hi = th; else lo = th;
      th = mid_floor(lo, hi);
    end
    return th;
  endfunction

  task automatic predict_thresholds();
    int L, m, lo, hi, split, bord;
    longint total, below, best, d;
    thr_beat_t b;
    L = cur_length;
    if (L < 2) L = 2;
    if (L > 16) L = 16;
    m = cur_mode;
    if (m == 3) m = 2;
    bord = sx24(cur_border);
    total = grid.size();
    lo = grid[0];
    hi = grid[0];
    foreach (grid[k]) begin
      if (grid[k] > hi) hi = grid[k];
      if (grid[k] < lo) lo = grid[k];
    end
    thr_table[0] = lo;
    thr_table[L] = hi;
    split = L / 2;
    if (m <= 1)
      for (int i = 1; i < L; i++) thr_table[i] = bisect_threshold(lo, hi, total * i / L);
    if (m != 0) begin
      if (m == 1) begin
        best = longint'(hi) - lo;
        for (int i = 1; i < L; i++) begin
          d = longint'(thr_table[i]) - bord;
          if (d < 0) d = -d;
          if (d < best) begin
            best = d;
            split = i;
          end
        end
      end
      thr_table[split] = bord;
      below = count_under(bord);
      for (int i = 1; i < split; i++)
        thr_table[i] = bisect_threshold(lo, bord, below * i / split);
      for (int i = split + 1; i < L; i++)
        thr_table[i] = bisect_threshold(bord, hi,
          below + (total - below) * (i - split) / (L - split));
    end
    for (int i = 0; i <= L; i++) begin
      b.index = i[4:0];
      b.value = thr_table[i][23:0];
      b.last  = (i == L);
      expected_thresholds.push_back(b);
    end
    grid.delete();
  endtask

  // input beat capture
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      grid.push_back(sx24(s_axis_tdata));
      if (s_axis_tlast) predict_thresholds();
      in_taken = 1'b1;
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      tx_free = !s_axis_tvalid || in_taken;
      if (in_taken) begin
        in_taken = 1'b0;
        tx_wait = $urandom_range(0, 8);
      end
      if (tx_free) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_samples[0].sample;
          s_axis_tlast  <= pending_samples[0].last;
          void'(pending_samples.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    thr_beat_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      rx_wait = $urandom_range(0, 8);
      if (expected_thresholds.size() == 0) begin
        $error("unexpected threshold beat index=%0d value=%h", m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        e = expected_thresholds.pop_front();
        if (m_axis_tuser !== e.index) begin
          $error("thr_index expected %0d got %0d", e.index, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata !== e.value) begin
          $error("thr_value expected %h got %h", e.value, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("thr_last expected %0d got %0d", e.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(ept_pkg::reg_index_t idx, logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ept_pkg::REG_MODE:   cur_mode = val[1:0];
      ept_pkg::REG_LENGTH: cur_length = val[4:0];
      ept_pkg::REG_BORDER: cur_border = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || s_axis_tvalid || expected_thresholds.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic queue_grid(int n, int kind);
    sample_beat_t b;
    for (int k = 0; k < n; k++) begin
      case (kind)
        0: b.sample = 24'($urandom);
        1: b.sample = 24'($urandom_range(0, 4095) - 2048);
        default: b.sample = 24'(($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000)
                                ^ ($urandom & 24'hFF));
      endcase
      b.last = (k == n - 1);
      pending_samples.push_back(b);
    end
  endtask

  task automatic set_all(logic [1:0] m, logic [4:0] l, logic [23:0] bv);
    write_reg(ept_pkg::REG_MODE, {22'd0, m});
    write_reg(ept_pkg::REG_LENGTH, {19'd0, l});
    write_reg(ept_pkg::REG_BORDER, bv);
  endtask

  initial begin
    sample_beat_t b;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, single sample, length clamping, mode 3
    set_all(ept_pkg::MODE_FLAT, 5'd2, 24'd0);
    b = '{24'h7FFFFF, 1'b0}; pending_samples.push_back(b);
    b = '{24'h800000, 1'b0}; pending_samples.push_back(b);
    b = '{24'h000000, 1'b0}; pending_samples.push_back(b);
    b = '{24'hFFFFFF, 1'b1}; pending_samples.push_back(b);
    b = '{24'h123456, 1'b1}; pending_samples.push_back(b);
    wait_drained();
    set_all(ept_pkg::MODE_SNAP, 5'd16, 24'h000100);
    queue_grid(6, 1);
    wait_drained();
    set_all(ept_pkg::MODE_HALF, 5'd0, 24'h7FFFFF);
    queue_grid(5, 2);
    wait_drained();
    set_all(2'd3, 5'd31, 24'h800000);
    queue_grid(5, 0);
    wait_drained();

    // random grids under varied settings
    for (int p = 0; p < 14; p++) begin
      set_all(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
              $urandom_range(0, 1) ? 24'($urandom_range(0, 4095) - 2048) : 24'($urandom));
      for (int g = 0; g < 3; g++) queue_grid($urandom_range(1, 8), $urandom_range(0, 2));
      wait_drained();
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

FILE: filelist.f
sv/ept_pkg.sv
sv/ept_ram.sv
sv/equalized_palette_thresholds_core.sv
tb/tb.sv
